// ===== hw/rtl/byte_budget_lru_eviction_table_top_assert.svh =====
// Assertion macros for the byte budget eviction table
`ifndef BYTE_BUDGET_LRU_EVICTION_TABLE_TOP_ASSERT_SVH
`define BYTE_BUDGET_LRU_EVICTION_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BBLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BBLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bblt_pkg.sv =====
// Shared types and constants of the byte budget eviction table
`default_nettype none
package bblt_pkg;

    localparam int DEF_ENTRIES  = 32;
    localparam int DEF_KEY_BITS = 32;

    localparam int CAP_W    = 20;
    localparam int SIZE_W   = 40;
    localparam int KEY_IN_W = 32;
    localparam int CNT_W    = 32;
    localparam int USED_W   = 41;

    localparam logic [CAP_W-1:0] CAP_RESET = 20'd1024;

    // 2^22 = 5 * 838860 + 4, so ceil(cap * 2^22 / 5) = cap * 838860 + ceil(4 * cap / 5)
    localparam logic [19:0] KEEP_MUL = 20'd838860;
    // floor(x / 5) = (x * ceil(2^24 / 5)) >> 24 for x below 2^22
    localparam logic [23:0] DIV5_MUL = 24'd3355444;
    localparam int          DIV5_SH  = 24;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_SUCCESS    = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_DISK_FULL  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [KEY_IN_W-1:0] key;
        logic [SIZE_W-1:0]   object_size;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic                present;
        logic                evicted_valid;
        logic [KEY_IN_W-1:0] evicted_key;
        logic [SIZE_W-1:0]   used_bytes;
        logic [CNT_W-1:0]    hit_total;
        logic [CNT_W-1:0]    miss_total;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic    load;
        logic    find;
        logic    cnt_hit;
        logic    cnt_miss;
        logic    drop_hit;
        logic    evict_step;
        logic    place;
        logic    tick_mul;
        logic    need_ins;
        logic    need_tick;
        logic    fin;
        t_status status;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic hit;
        logic size_zero;
        logic over_budget;
        logic tick_over;
        logic freed_ok;
        logic any_valid;
        logic slot_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/bblt_ctrl.sv =====
// Sequencer of the byte budget eviction table
`default_nettype none
module bblt_ctrl
    import bblt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    output logic         o_busy,
    input  t_dp_sts      i_sts,
    output t_dp_ctl      o_ctl
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_TMUL  = 7'b0000100,
        S_TCHK  = 7'b0001000,
        S_EVICT = 7'b0010000,
        S_PLACE = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_SUCCESS;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_ctl    = '0;
        o_ctl.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.find = 1'b1;
                n_status   = ST_SUCCESS;
                n_state    = S_FIN;
                unique case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.hit) begin
                            o_ctl.cnt_hit = 1'b1;
                        end else begin
                            o_ctl.cnt_miss = 1'b1;
                            if (i_sts.size_zero) begin
                                n_status = ST_NOT_FOUND;
                            end else if (i_sts.over_budget) begin
                                o_ctl.need_ins = 1'b1;
                                n_state        = S_EVICT;
                            end else begin
                                n_state = S_PLACE;
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (i_sts.hit) o_ctl.drop_hit = 1'b1;
                        else           n_status       = ST_NOT_FOUND;
                    end
                    CMD_QUERY: begin
                    end
                    CMD_TICK: begin
                        o_ctl.tick_mul = 1'b1;
                        n_state        = S_TMUL;
                    end
                    default: begin
                    end
                endcase
            end
            S_TMUL: begin
                n_state = S_TCHK;
            end
            S_TCHK: begin
                if (i_sts.tick_over) begin
                    o_ctl.need_tick = 1'b1;
                    n_state         = S_EVICT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_EVICT: begin
                priority if (i_sts.freed_ok) begin
                    n_state = (i_sts.cmd == CMD_INSERT) ? S_PLACE : S_FIN;
                end else if (!i_sts.any_valid) begin
                    n_status = (i_sts.cmd == CMD_INSERT) ? ST_DISK_FULL : ST_SUCCESS;
                    n_state  = S_FIN;
                end else begin
                    o_ctl.evict_step = 1'b1;
                end
            end
            S_PLACE: begin
                if (i_sts.slot_free) o_ctl.place = 1'b1;
                else                 n_status    = ST_TABLE_FULL;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_ctl.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/bblt_datapath.sv =====
// Entry table, byte accounting and result register of the eviction table
`default_nettype none
module bblt_datapath
    import bblt_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  t_in_item            i_item,
    input  wire logic           i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    input  t_dp_ctl             i_ctl,
    output t_dp_sts             o_sts,
    output logic                o_res_strobe,
    output t_out_item           o_res
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW = $clog2(ENTRIES + 1);
    localparam int SW = SIZE_W + NW;
    localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam logic [SW-1:0] USED_MAX = SW'({USED_W{1'b1}});

    logic [CAP_W-1:0]  r_cap;
    logic [1:0]        r_cmd;
    logic [KW-1:0]     r_key;
    logic [SIZE_W-1:0] r_size;

    logic [ENTRIES-1:0] r_valid;
    logic [KW-1:0]      r_ekey  [ENTRIES];
    logic [SIZE_W-1:0]  r_esize [ENTRIES];
    logic [EW-1:0]      r_erank [ENTRIES];

    logic [SW-1:0]     r_sum;
    logic [NW-1:0]     r_nvalid;
    logic [CNT_W-1:0]  r_hits, r_misses;
    logic              r_present;
    logic [USED_W-1:0] r_need;
    logic [SW-1:0]     r_freed;
    logic [KW-1:0]     r_evkey;
    logic              r_pend;
    logic [21:0]       r_q;
    logic [SIZE_W-1:0] r_base;

    // parallel searches over the table
    logic          hit;
    logic [EW-1:0] hit_idx, old_idx, slot_idx;
    logic          any_old, slot_free;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        any_old  = 1'b0;
        old_idx  = '0;
        slot_free = 1'b0;
        slot_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_ekey[i] == r_key) begin
                hit     = 1'b1;
                hit_idx = EW'(i);
            end
            if (r_valid[i] && r_erank[i] == '0) begin
                any_old = 1'b1;
                old_idx = EW'(i);
            end
            if (!r_valid[i]) begin
                slot_free = 1'b1;
                slot_idx  = EW'(i);
            end
        end
    end

    logic          do_drop;
    logic [EW-1:0] drop_idx;
    logic [EW-1:0] drop_rank;

    assign do_drop   = i_ctl.evict_step | i_ctl.drop_hit;
    assign drop_idx  = i_ctl.evict_step ? old_idx : hit_idx;
    assign drop_rank = r_erank[drop_idx];

    // byte totals
    logic [USED_W-1:0]   used_sat;
    logic [SIZE_W-1:0]   used_out;
    logic [SIZE_W-1:0]   budget;
    logic [USED_W:0]     ins_total;
    logic [44:0]         used10, bud9;
    logic [21:0]         cap4;
    logic [21:0]         rem5;
    logic [USED_W-1:0]   keep;

    assign used_sat  = (r_sum > USED_MAX) ? USED_W'(USED_MAX) : r_sum[USED_W-1:0];
    assign used_out  = used_sat[USED_W-1] ? {SIZE_W{1'b1}} : used_sat[SIZE_W-1:0];
    assign budget    = {r_cap, 20'd0};
    assign ins_total = {1'b0, used_sat} + {2'b00, r_size};
    assign used10    = {4'd0, used_sat} * 45'd10;
    assign bud9      = {5'd0, budget} * 45'd9;
    assign cap4      = {r_cap, 2'b00};
    assign rem5      = cap4 - 22'(r_q * 22'd5);
    assign keep      = {1'b0, r_base} + {19'd0, r_q} + {{(USED_W-1){1'b0}}, (rem5 != '0)};

    always_comb begin
        o_sts.cmd         = t_cmd'(r_cmd);
        o_sts.hit         = hit;
        o_sts.size_zero   = (r_size == '0);
        o_sts.over_budget = ins_total > {2'b00, budget};
        o_sts.tick_over   = used10 > bud9;
        o_sts.freed_ok    = r_freed >= SW'(r_need);
        o_sts.any_valid   = any_old;
        o_sts.slot_free   = slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= CAP_RESET;
            r_valid      <= '0;
            r_sum        <= '0;
            r_nvalid     <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_pend       <= 1'b0;
            o_res_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_ctl.cnt_hit && r_hits != '1) r_hits <= r_hits + 1'b1;
            if (i_ctl.cnt_miss && r_misses != '1) r_misses <= r_misses + 1'b1;
            if (do_drop) begin
                r_valid[drop_idx] <= 1'b0;
                r_sum    <= r_sum - SW'(r_esize[drop_idx]);
                r_nvalid <= r_nvalid - 1'b1;
            end else if (i_ctl.place) begin
                r_valid[slot_idx] <= 1'b1;
                r_sum    <= r_sum + SW'(r_size);
                r_nvalid <= r_nvalid + 1'b1;
            end
            // an eviction step is registered in r_pend, then in o_res_strobe
            r_pend       <= i_ctl.evict_step;
            o_res_strobe <= r_pend | i_ctl.fin;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_item.cmd;
            r_key  <= i_item.key[KW-1:0];
            r_size <= i_item.object_size;
        end
        if (i_ctl.find) r_present <= hit;
        for (int i = 0; i < ENTRIES; i++) begin
            if (do_drop) begin
                if (r_valid[i] && r_erank[i] > drop_rank) r_erank[i] <= r_erank[i] - 1'b1;
            end else if (i_ctl.place && slot_idx == EW'(i)) begin
                r_erank[i] <= r_nvalid[EW-1:0];
                r_ekey[i]  <= r_key;
                r_esize[i] <= r_size;
            end
        end
        if (i_ctl.tick_mul) begin
            r_q    <= 22'((46'(cap4) * 46'(DIV5_MUL)) >> DIV5_SH);
            r_base <= 40'(r_cap) * 40'(KEEP_MUL);
        end
        if (i_ctl.need_ins) begin
            r_need  <= {1'b0, r_size};
            r_freed <= '0;
        end else if (i_ctl.need_tick) begin
            r_need  <= used_sat - keep;
            r_freed <= '0;
        end else if (i_ctl.evict_step) begin
            r_freed <= r_freed + SW'(r_esize[old_idx]);
        end
        if (i_ctl.evict_step) r_evkey <= r_ekey[old_idx];

        o_res.used_bytes <= used_out;
        o_res.hit_total  <= r_hits;
        o_res.miss_total <= r_misses;
        if (r_pend) begin
            o_res.status        <= ST_SUCCESS;
            o_res.present       <= 1'b0;
            o_res.evicted_valid <= 1'b1;
            o_res.evicted_key   <= KEY_IN_W'(r_evkey);
            o_res.last          <= 1'b0;
        end else begin
            o_res.status        <= i_ctl.status;
            o_res.present       <= r_present;
            o_res.evicted_valid <= 1'b0;
            o_res.evicted_key   <= '0;
            o_res.last          <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/byte_budget_lru_eviction_table_top.sv =====
// Top level of the byte budget eviction table
//
//  channel   signals                          beat taken when
//  command   start, busy, i_item              start && !busy
//  result    o_res_strobe, o_res              o_res_strobe (one cycle, no stall)
//  config    i_cfg_valid, o_cfg_ready, data   i_cfg_valid && o_cfg_ready
//
// Query, remove and insert hit pass through EXEC and FIN; an insert that
// stores adds PLACE. Each evicted entry adds a pass of the EVICT loop plus
// one closing check; a tick adds TMUL and TCHK for the trim-threshold
// multiply. Eviction steps are registered in r_pend, then in o_res_strobe;
// the closing beat shows the cycle after the final state.
// Reset clears the valid bits at once; no sweep.
`default_nettype none
module byte_budget_lru_eviction_table_top
    import bblt_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_res_strobe,
    output t_out_item             o_res,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    bblt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    bblt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/bblt_checker.sv =====
// Port-level checks of the byte budget eviction table
`default_nettype none
`include "byte_budget_lru_eviction_table_top_assert.svh"
module bblt_checker
    import bblt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_res_strobe,
    input t_out_item o_res
);

    // an accepted command keeps the block busy next cycle
    `BBLT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after accept")
    // the closing beat is never followed directly by another beat
    `BBLT_ASSERT_NXT(a_last_gap, i_clk, i_rst_n, o_res_strobe && o_res.last, !o_res_strobe,
                     "beat right after closing beat")
    // only eviction beats are not last, and they carry success
    `BBLT_ASSERT_IMP(a_evict_row, i_clk, i_rst_n, o_res_strobe && !o_res.last,
                     o_res.evicted_valid && o_res.status == ST_SUCCESS && !o_res.present,
                     "malformed eviction beat")
    // while idle only a closing beat can show
    `BBLT_ASSERT_IMP(a_idle_last, i_clk, i_rst_n, o_res_strobe && !busy, o_res.last,
                     "eviction beat while idle")

endmodule

bind byte_budget_lru_eviction_table_top bblt_checker u_bblt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);
`default_nettype wire

// ===== test/tb_byte_budget_lru_eviction_table_top.sv =====
// Self-checking testbench for the byte budget LRU eviction table top level
`default_nettype none
module tb_byte_budget_lru_eviction_table_top
    import bblt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT      = DEF_ENTRIES;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [63:0] USED_SAT = (64'd1 << 41) - 64'd1;
    localparam logic [63:0] SIZE_ALL = (64'd1 << 40) - 64'd1;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] key;
        logic [39:0] size;
        bit          chk;
        t_status     st;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in_item         i_item = '0;
    logic             o_res_strobe;
    t_out_item        o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data = '0;

    byte_budget_lru_eviction_table_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the table
    logic             slot_v[NSLOT];
    logic [31:0]      slot_key[NSLOT];
    logic [39:0]      slot_size[NSLOT];
    int               slot_age[NSLOT];
    logic [63:0]      held_bytes;
    logic [31:0]      hit_cnt;
    logic [31:0]      miss_cnt;
    logic [CAP_W-1:0] cap_mb;

    t_out_item expected_rows[$];
    bit        typed_chk[$];
    t_status   typed_st[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    bit        gaps_on = 1'b1;
    t_row      dir_rows[$];

    function automatic void sum_bytes();
        logic [63:0] s;
        s = 0;
        for (int i = 0; i < NSLOT; i++)
            if (slot_v[i]) s += slot_size[i];
        held_bytes = (s > USED_SAT) ? USED_SAT : s;
    endfunction

    function automatic void push_row(t_status st, logic pres, logic ev, logic [31:0] evk,
                                     logic lst);
        t_out_item r;
        r.status        = st;
        r.present       = pres;
        r.evicted_valid = ev;
        r.evicted_key   = evk;
        r.used_bytes    = (held_bytes > SIZE_ALL) ? SIZE_ALL[39:0] : held_bytes[39:0];
        r.hit_total     = hit_cnt;
        r.miss_total    = miss_cnt;
        r.last          = lst;
        expected_rows.push_back(r);
    endfunction

    function automatic void drop_slot(int idx);
        int r;
        r = slot_age[idx];
        slot_v[idx] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            if (slot_v[i] && slot_age[i] > r) slot_age[i]--;
        sum_bytes();
    endfunction

    // evict oldest entries until need bytes are freed; 1 when enough came free
    function automatic bit evict_oldest(logic [63:0] need);
        logic [63:0] freed;
        int idx;
        freed = 0;
        while (freed < need) begin
            idx = -1;
            for (int i = 0; i < NSLOT; i++)
                if (slot_v[i] && (idx < 0 || slot_age[i] < slot_age[idx])) idx = i;
            if (idx < 0) break;
            freed += slot_size[idx];
            drop_slot(idx);
            push_row(ST_SUCCESS, 1'b0, 1'b1, slot_key[idx], 1'b0);
        end
        return freed >= need;
    endfunction

    function automatic void predict_table(t_in_item it);
        logic [63:0] budget, keep;
        int idx, slot, nvalid;
        logic pres;
        budget = {24'd0, cap_mb, 20'd0};
        idx = -1;
        for (int i = 0; i < NSLOT; i++)
            if (idx < 0 && slot_v[i] && slot_key[i] == it.key) idx = i;
        pres = (idx >= 0);
        case (t_cmd'(it.cmd))
            CMD_INSERT: begin
                if (pres) begin
                    if (hit_cnt != '1) hit_cnt++;
                    push_row(ST_SUCCESS, 1'b1, 1'b0, '0, 1'b1);
                    return;
                end
                if (miss_cnt != '1) miss_cnt++;
                if (it.object_size == 0) begin
                    push_row(ST_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
                    return;
                end
                if (held_bytes + it.object_size > budget) begin
                    if (!evict_oldest(64'(it.object_size))) begin
                        push_row(ST_DISK_FULL, 1'b0, 1'b0, '0, 1'b1);
                        return;
                    end
                end
                slot = -1;
                nvalid = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (slot_v[i]) nvalid++;
                    else if (slot < 0) slot = i;
                end
                if (slot < 0) begin
                    push_row(ST_TABLE_FULL, 1'b0, 1'b0, '0, 1'b1);
                    return;
                end
                slot_age[slot]  = nvalid;
                slot_v[slot]    = 1'b1;
                slot_key[slot]  = it.key;
                slot_size[slot] = it.object_size;
                sum_bytes();
                push_row(ST_SUCCESS, 1'b0, 1'b0, '0, 1'b1);
            end
            CMD_REMOVE: begin
                if (!pres) begin
                    push_row(ST_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    drop_slot(idx);
                    push_row(ST_SUCCESS, 1'b1, 1'b0, '0, 1'b1);
                end
            end
            CMD_QUERY: push_row(ST_SUCCESS, pres, 1'b0, '0, 1'b1);
            default: begin
                if (held_bytes * 10 > budget * 9) begin
                    keep = (budget * 4 + 4) / 5;
                    void'(evict_oldest(held_bytes - keep));
                end
                push_row(ST_SUCCESS, pres, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    // one command beat; start stays high when the next item follows at once
    task automatic send_item(t_in_item it, bit chk, t_status st);
        while (gaps_on && $urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_table(it);
        typed_chk.push_back(chk);
        typed_st.push_back(st);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        start <= 1'b0;
        wait (expected_rows.size() == 0);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_mb = v;
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        logic [63:0] base, span;
        int roll;
        roll = $urandom_range(0, 99);
        it.cmd = (roll < 52) ? CMD_INSERT : (roll < 67) ? CMD_REMOVE :
                 (roll < 80) ? CMD_QUERY : CMD_TICK;
        it.key = ($urandom_range(0, 99) < 85) ? 32'($urandom_range(0, 47)) : $urandom;
        base = (cap_mb == 0) ? (64'd1 << 20) : {24'd0, cap_mb, 20'd0};
        span = base / 3;
        roll = $urandom_range(0, 99);
        if (roll < 8)       it.object_size = '0;
        else if (roll < 14) it.object_size = {$urandom, $urandom};
        else if (roll < 17) it.object_size = '1;
        else                it.object_size = 40'(({$urandom, $urandom} % span) + 1);
        return it;
    endfunction

    function automatic void add_row(t_cmd c, logic [31:0] k, logic [39:0] s, bit chk,
                                    t_status st);
        t_row r;
        r.cmd = c; r.key = k; r.size = s; r.chk = chk; r.st = st;
        dir_rows.push_back(r);
    endfunction

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_res_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            if (o_res_strobe) begin
                if (expected_rows.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_rows.pop_front();
                    if (o_res.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_res.status); errors++;
                    end
                    if (o_res.present !== e.present) begin
                        $error("present exp %0d got %0d", e.present, o_res.present); errors++;
                    end
                    if (o_res.evicted_valid !== e.evicted_valid) begin
                        $error("evicted_valid exp %0d got %0d", e.evicted_valid,
                               o_res.evicted_valid); errors++;
                    end
                    if (o_res.evicted_key !== e.evicted_key) begin
                        $error("evicted_key exp %0h got %0h", e.evicted_key,
                               o_res.evicted_key); errors++;
                    end
                    if (o_res.used_bytes !== e.used_bytes) begin
                        $error("used_bytes exp %0h got %0h", e.used_bytes,
                               o_res.used_bytes); errors++;
                    end
                    if (o_res.hit_total !== e.hit_total) begin
                        $error("hit_total exp %0d got %0d", e.hit_total, o_res.hit_total);
                        errors++;
                    end
                    if (o_res.miss_total !== e.miss_total) begin
                        $error("miss_total exp %0d got %0d", e.miss_total, o_res.miss_total);
                        errors++;
                    end
                    if (o_res.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_res.last); errors++;
                    end
                    if (e.last && typed_chk.size() > 0) begin
                        if (typed_chk.pop_front() && o_res.status !== typed_st[0]) begin
                            $error("status exp %0d got %0d", typed_st[0], o_res.status);
                            errors++;
                        end
                        void'(typed_st.pop_front());
                    end
                end
            end
        end
    end

    initial begin
        t_in_item it;
        logic [CAP_W-1:0] caps[6];
        for (int i = 0; i < NSLOT; i++) begin
            slot_v[i] = 1'b0; slot_key[i] = '0; slot_size[i] = '0; slot_age[i] = 0;
        end
        held_bytes = 0; hit_cnt = 0; miss_cnt = 0; cap_mb = CAP_RESET;

        add_row(CMD_QUERY,  32'd0,         40'd0,          1, ST_SUCCESS);
        add_row(CMD_REMOVE, 32'hFFFF_FFFF, 40'd0,          1, ST_NOT_FOUND);
        add_row(CMD_INSERT, 32'd1,         40'd0,          1, ST_NOT_FOUND);
        add_row(CMD_INSERT, 32'd1,         40'd1000,       1, ST_SUCCESS);
        add_row(CMD_INSERT, 32'd1,         40'd5,          1, ST_SUCCESS);
        add_row(CMD_QUERY,  32'd1,         40'd0,          1, ST_SUCCESS);
        add_row(CMD_INSERT, 32'd2,         '1,             1, ST_DISK_FULL);
        add_row(CMD_INSERT, 32'd3,         40'd1 << 30,    1, ST_SUCCESS);
        add_row(CMD_INSERT, 32'd4,         40'd1,          1, ST_SUCCESS);
        add_row(CMD_TICK,   32'd4,         '1,             1, ST_SUCCESS);
        add_row(CMD_REMOVE, 32'd4,         40'd0,          1, ST_SUCCESS);
        // fill every slot, then one more insert finds no room
        for (int k = 0; k < NSLOT; k++)
            add_row(CMD_INSERT, 32'(100 + k), 40'(k + 1), 0, ST_SUCCESS);
        add_row(CMD_INSERT, 32'd200,       40'd7,          1, ST_TABLE_FULL);
        add_row(CMD_TICK,   32'd0,         40'd0,          1, ST_SUCCESS);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            it.cmd = dir_rows[i].cmd;
            it.key = dir_rows[i].key;
            it.object_size = dir_rows[i].size;
            send_item(it, dir_rows[i].chk, dir_rows[i].st);
        end

        caps[0] = 20'd1;
        caps[1] = 20'd3;
        caps[2] = 20'd0;
        caps[3] = 20'hF_FFFF;
        caps[4] = 20'd2;
        caps[5] = 20'($urandom_range(1, 16));
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            gaps_on = (p != 1);
            repeat (52) send_item(random_item(), 1'b0, ST_SUCCESS);
        end

        start <= 1'b0;
        wait (expected_rows.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bblt_pkg.sv
hw/rtl/bblt_ctrl.sv
hw/rtl/bblt_datapath.sv
hw/rtl/byte_budget_lru_eviction_table_top.sv
hw/rtl/bblt_checker.sv
test/tb_byte_budget_lru_eviction_table_top.sv
